FILE: rtl/wpm_pkg.sv
package wpm_pkg;

  localparam int unsigned MaxPattern = 16;
  localparam int unsigned RowW       = MaxPattern + 1;
  localparam int unsigned LenW       = 5;
  localparam int unsigned PatW       = 8 * MaxPattern;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned RowDepth   = 2;

  localparam logic [7:0] StarByte = 8'h2A;
  localparam logic [7:0] AnyByte  = 8'h3F;

  localparam logic [CfgIdxW-1:0] CfgLength  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPatHigh = 2'd2;

  localparam logic FuncStart = 1'b0;

  // one item as latched for the update cycle
  typedef struct packed {
    logic       start;
    logic [7:0] text_byte;
  } cmd_t;

endpackage

FILE: rtl/wpm_ram.sv
module wpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/wpm_row_update.sv
module wpm_row_update (
  input  wpm_pkg::cmd_t                 cmd_i,
  input  logic [wpm_pkg::PatW-1:0]      pattern_i,
  input  logic [wpm_pkg::RowW-1:0]      row_i,
  output logic [wpm_pkg::RowW-1:0]      row_o
);

  logic [wpm_pkg::RowW-1:0] row_new;

  // position 0: empty prefix matches only the empty text
  assign row_new[0] = cmd_i.start;

  // one cell per pattern position; start behaves as an all-zero old row
  for (genvar j = 1; j < int'(wpm_pkg::RowW); j++) begin : g_cell
    logic [7:0] pc;
    logic       is_star;
    logic       hit;
    assign pc      = pattern_i[8*(j-1) +: 8];
    assign is_star = (pc == wpm_pkg::StarByte);
    assign hit     = !cmd_i.start &&
                     ((pc == wpm_pkg::AnyByte) || (pc == cmd_i.text_byte));
    assign row_new[j] = is_star ? ((row_i[j] && !cmd_i.start) || row_new[j-1])
                                : (hit && row_i[j-1]);
  end

  assign row_o = row_new;

endmodule

FILE: rtl/wildcard_pattern_matcher.sv
// Result: the row RAM is read and the item registered when the item is accepted,
//   then the row update goes into the output register; this waits only while the
//   output item is stalled.
// Flow: a new item waits until the last one's row update is written (in_stall_o high).
// Reset: asynchronous, active low; pattern registers and length clear to zero,
//   both row entries read as all zeros until first written, no output pending.
module wildcard_pattern_matcher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wpm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wpm_pkg::CfgDataW-1:0]  cfg_data_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [7:0]                    text_byte_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          matched_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [wpm_pkg::LenW-1:0] len_q;
  logic [wpm_pkg::PatW-1:0] pattern_q;
  logic                     cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      pattern_q <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        wpm_pkg::CfgLength:  len_q <= cfg_data_i[wpm_pkg::LenW-1:0];
        wpm_pkg::CfgPatLow:  pattern_q[63:0] <= cfg_data_i;
        wpm_pkg::CfgPatHigh: pattern_q[127:64] <= cfg_data_i;
        default: ; // unused index, write dropped
      endcase
    end
  end

  // length clamped to the number of pattern cells
  logic [wpm_pkg::LenW-1:0] used_len;
  assign used_len = (len_q > wpm_pkg::LenW'(wpm_pkg::MaxPattern))
                  ? wpm_pkg::LenW'(wpm_pkg::MaxPattern) : len_q;

  // handshakes
  logic in_acc;
  logic out_free;
  logic done;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign done       = (state_q == ST_CALC) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_CALC;
      ST_CALC: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // item held for the update cycle
  wpm_pkg::cmd_t cmd_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q.start     <= (func_i == wpm_pkg::FuncStart);
      cmd_q.text_byte <= text_byte_i;
    end
  end

  // Row RAM, two entries used ping-pong: the current row is read from entry
  // ptr_q and the next row written to the other, so a read never meets a
  // write of the same entry. Per-entry valid bits stand in for the reset.
  logic                       ptr_q;
  logic [1:0]                 row_vld_q;
  logic                       rd_ok_q;
  logic [wpm_pkg::RowW-1:0]   ram_rdata;
  logic [wpm_pkg::RowW-1:0]   row_cur;
  logic [wpm_pkg::RowW-1:0]   row_next;

  wpm_ram #(
    .WIDTH (wpm_pkg::RowW),
    .DEPTH (wpm_pkg::RowDepth)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (done),
    .waddr_i (!ptr_q),
    .wdata_i (row_next),
    .re_i    (in_acc),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  assign row_cur = rd_ok_q ? ram_rdata : '0;

  wpm_row_update u_update (
    .cmd_i     (cmd_q),
    .pattern_i (pattern_q),
    .row_i     (row_cur),
    .row_o     (row_next)
  );

  // output register
  logic out_valid_q;
  logic matched_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= 1'b0;
      row_vld_q   <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        rd_ok_q <= row_vld_q[ptr_q];
      end
      if (done) begin
        ptr_q             <= !ptr_q;
        row_vld_q[!ptr_q] <= 1'b1;
        out_valid_q       <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      matched_q <= row_next[used_len];
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

  // checks
  a_acc_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_CALC))
    else $error("accepted item did not enter the update cycle");

  a_ptr_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (ptr_q != $past(ptr_q)) && row_vld_q[$past(!ptr_q)])
    else $error("row pointer did not move to the freshly written entry");

  a_out_from_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_CALC))
    else $error("result raised without an update cycle");

  a_start_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && cmd_q.start) |=> row_vld_q[ptr_q])
    else $error("start item left the current row entry invalid");

endmodule

FILE: sim/wildcard_pattern_matcher_test.sv
module wildcard_pattern_matcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wpm_pkg::*;

  // text byte item; the package only names the begin code
  localparam logic FuncByte = 1'b1;

  localparam logic [7:0] LetterA = 8'h61;

  localparam int unsigned ItemTarget = 1200;
  localparam int unsigned MaxGap     = 18;
  // watchdog limit, many times what the slowest legal run needs
  localparam int unsigned CycleLimit = 600000;
  // spare cycles after the last result, to let the block settle
  localparam int unsigned SettleCycles = 4;

  // Golden model of the matcher plus the queue of outstanding match flags.
  // Keeps the full DP row so a length change mid-text reads the right prefix.
  class glob_match_board;
    logic [LenW-1:0] pat_len;
    logic [7:0]      pat [MaxPattern];
    logic [RowW-1:0] row;
    logic            matched_q [$];
    int unsigned     errors;

    function new();
      pat_len = '0;
      foreach (pat[k]) pat[k] = '0;
      row    = '0;
      errors = 0;
    endfunction

    function void configure(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgLength: pat_len = data[LenW-1:0];
        CfgPatLow: begin
          for (int k = 0; k < 8; k++) pat[k] = data[8*k +: 8];
        end
        CfgPatHigh: begin
          for (int k = 0; k < 8; k++) pat[8+k] = data[8*k +: 8];
        end
        default: ;
      endcase
    endfunction

    function void note_item(logic fn, logic [7:0] c);
      logic [RowW-1:0] nxt;
      int unsigned     used;
      nxt = '0;
      // begin: empty text matches the empty prefix and any run of leading stars
      if (fn == FuncStart) nxt[0] = 1'b1;
      for (int j = 1; j <= MaxPattern; j++) begin
        if (fn == FuncStart)
          nxt[j] = (pat[j-1] == StarByte) & nxt[j-1];
        else if (pat[j-1] == StarByte)
          nxt[j] = row[j] | nxt[j-1];
        else if (pat[j-1] == AnyByte || pat[j-1] == c)
          nxt[j] = row[j-1];
      end
      row  = nxt;
      used = (pat_len > MaxPattern) ? MaxPattern : pat_len;
      matched_q.push_back(row[used]);
    endfunction

    function void check_result(logic got);
      logic want;
      if (matched_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("matched=%0b arrived with no item outstanding", got);
        return;
      end
      want = matched_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("matched mismatch: expected %0b, got %0b", want, got);
      end
    endfunction

    function int unsigned pending();
      return matched_q.size();
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                func_i      = 1'b0;
  logic [7:0]          text_byte_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                matched_o;

  glob_match_board sb = new();

  // pattern as the stimulus side sees it; mirrored into the block by write_config
  logic [LenW-1:0] cur_len;
  logic [7:0]      cur_pat [MaxPattern];

  // per-phase switches: off gives stretches with back-to-back traffic
  bit          gaps_on  = 1'b1;
  bit          stall_on = 1'b1;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;

  wildcard_pattern_matcher i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .text_byte_i (text_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .matched_o   (matched_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // One item per call. Valid is left high after acceptance: the next call
  // either drops it for a gap or loads the next payload in the same step,
  // so valid never gets two assignments in one step.
  task automatic send_item(input logic fn, input logic [7:0] txt);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, MaxGap) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= fn;
    text_byte_i <= txt;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(fn, txt);
    items_sent++;
  endtask

  // Stop sending and let every outstanding result come back; block is idle after.
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes length, low and high pattern words back to back.
  task automatic write_config();
    logic [CfgIdxW-1:0]  regs [3] = '{CfgLength, CfgPatLow, CfgPatHigh};
    logic [CfgDataW-1:0] word [3];
    word[0] = CfgDataW'(cur_len);
    for (int k = 0; k < 8; k++) begin
      word[1][8*k +: 8] = cur_pat[k];
      word[2][8*k +: 8] = cur_pat[8+k];
    end
    cfg_valid_i <= 1'b1;
    for (int r = 0; r < 3; r++) begin
      cfg_index_i <= regs[r];
      cfg_data_i  <= word[r];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.configure(regs[r], word[r]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic fill_pattern(input logic [7:0] b);
    foreach (cur_pat[k]) cur_pat[k] = b;
  endtask

  // mostly a small alphabet so literal bytes line up often
  function automatic logic [7:0] random_text_byte();
    if ($urandom_range(0, 3) != 0) return LetterA + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] random_pattern_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return LetterA + 8'($urandom_range(0, 2));
      3, 4:    return StarByte;
      5:       return AnyByte;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Begin item followed by a text built from the pattern: literals copied,
  // '?' gets any byte, '*' a short run. Now and then one byte is broken.
  task automatic send_text();
    logic [7:0]  text_q [$];
    int unsigned used;
    int unsigned pos;
    used = (cur_len > MaxPattern) ? MaxPattern : cur_len;
    for (int j = 0; j < used; j++) begin
      if (cur_pat[j] == StarByte)
        repeat ($urandom_range(0, 3)) text_q.push_back(random_text_byte());
      else if (cur_pat[j] == AnyByte)
        text_q.push_back(8'($urandom_range(0, 255)));
      else
        text_q.push_back(cur_pat[j]);
    end
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0: if (text_q.size() != 0) begin
          pos = $urandom_range(0, text_q.size() - 1);
          text_q[pos] = random_text_byte();
        end
        1: if (text_q.size() != 0) begin
          pos = $urandom_range(0, text_q.size() - 1);
          text_q.delete(pos);
        end
        default: text_q.push_back(random_text_byte());
      endcase
    end
    send_item(FuncStart, 8'($urandom_range(0, 255)));
    foreach (text_q[i]) send_item(FuncByte, text_q[i]);
  endtask

  // random func and byte, no structure
  task automatic send_noise(input int unsigned count);
    repeat (count) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  // Result side: draw a stall length per item, then accept one result.
  initial begin : result_side
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = stall_on ? $urandom_range(0, MaxGap) : 0;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(matched_o);
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned pick;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // registers at reset: empty pattern. Bytes before any begin see a zero row.
    cur_len = '0;
    fill_pattern(8'h00);
    send_item(FuncByte, 8'hFF);
    send_item(FuncByte, 8'h00);
    // empty pattern matches empty text only; zero byte is plain data
    send_item(FuncStart, 8'h00);
    send_item(FuncByte, 8'h00);
    wait_results_done();

    // all stars with a length past the maximum: clamps to 16, matches anything
    cur_len = 5'd31;
    fill_pattern(StarByte);
    write_config();
    send_item(FuncStart, 8'hFF);
    send_item(FuncByte, 8'hFF);
    send_item(FuncByte, 8'h00);
    wait_results_done();

    // zero byte, wildcard and 0xFF as literal pattern bytes
    cur_len = 5'd3;
    fill_pattern(8'hFF);
    cur_pat[0] = 8'h00;
    cur_pat[1] = AnyByte;
    write_config();
    send_item(FuncStart, 8'h00);
    send_item(FuncByte, 8'h00);
    send_item(FuncByte, 8'h80);
    send_item(FuncByte, 8'hFF);
    wait_results_done();

    // shorter length mid-text: row kept, shorter prefix read at once
    cur_len = 5'd2;
    write_config();
    send_item(FuncByte, 8'hFF);
    wait_results_done();

    // star between literals, full length 16 with the rest as wildcards
    cur_len = 5'd16;
    fill_pattern(StarByte);
    cur_pat[0] = LetterA;
    cur_pat[2] = LetterA + 8'd1;
    write_config();
    send_item(FuncStart, 8'h00);
    send_item(FuncByte, LetterA);
    send_item(FuncByte, LetterA + 8'd1);
    send_item(FuncByte, 8'h78);
    send_item(FuncByte, LetterA + 8'd1);
    wait_results_done();

    // --- random phases ---
    phase = 0;
    while (items_sent < ItemTarget) begin
      // block is drained here, so the sender has paused for every result
      wait_results_done();
      for (int k = 0; k < MaxPattern; k++) cur_pat[k] = random_pattern_byte();
      case (phase % 10)
        3:       fill_pattern(StarByte);
        5:       fill_pattern(8'h00);
        7:       fill_pattern(8'hFF);
        default: ;
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0)      cur_len = '0;
      else if (pick == 1) cur_len = 5'd16;
      else if (pick == 2) cur_len = 5'($urandom_range(17, 31));
      else                cur_len = 5'($urandom_range(1, 16));
      write_config();
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);

      // keep going on the old text under the new pattern now and then
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 4)) send_item(FuncByte, random_text_byte());

      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 6) != 0) send_text();
        else send_noise($urandom_range(1, 10));
      end
      phase++;
    end

    wait_results_done();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
